/* rtl/core/magnetometer_hard_iron_correction_defines.svh */
// Assertion macros shared by the magnetometer hard-iron correction RTL.
`ifndef MAGNETOMETER_HARD_IRON_CORRECTION_DEFINES_SVH
`define MAGNETOMETER_HARD_IRON_CORRECTION_DEFINES_SVH

`ifndef SYNTHESIS
`define MHIC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MHIC_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define MHIC_ASSERT(lbl, clk, rst, prop, msg)
`define MHIC_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

/* rtl/core/mhic_pkg.sv */
// Types and constants of the magnetometer hard-iron correction block.
package mhic_pkg;

   localparam int SampleW = 16;
   localparam int GainW   = 16;
   localparam int CsrAddrW = 2;

   typedef enum logic [1:0] {
      ACT_SAMPLE    = 2'd0,
      ACT_CAL_BEGIN = 2'd1,
      ACT_CAL_END   = 2'd2
   } action_type;

   localparam logic [CsrAddrW-1:0] CSR_GAIN_X   = 2'd0;
   localparam logic [CsrAddrW-1:0] CSR_GAIN_Y   = 2'd1;
   localparam logic [CsrAddrW-1:0] CSR_GAIN_Z   = 2'd2;
   localparam logic [CsrAddrW-1:0] CSR_PASS_RAW = 2'd3;

   localparam logic [GainW-1:0] GainOne = 16'd4096;

   typedef struct packed {
      logic load;       // item moves into the result register
      logic cal_begin;
      logic cal_end;
      logic tracking;   // tracking state before this item
      logic pass_raw;
   } axis_ctl_type;

endpackage

/* rtl/core/mhic_axis.sv */
// One axis: gain, offset subtraction with saturation and min/max calibration state; raw mode passes the input through.
`include "magnetometer_hard_iron_correction_defines.svh"

module mhic_axis
   import mhic_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  axis_ctl_type              ctl,
   input  logic signed [SampleW-1:0] raw_val,
   input  logic        [GainW-1:0]   gain,
   output logic signed [SampleW-1:0] corr
);

   localparam int ProdW = SampleW + GainW + 1;
   localparam logic signed [ProdW-1:0] GainBias = ProdW'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
   localparam logic signed [ProdW-1:0] SatHi = ProdW'(32767);
   localparam logic signed [ProdW-1:0] SatLo = -ProdW'(32768);

   logic signed [SampleW-1:0] offset_ff, offset_in;
   logic signed [SampleW-1:0] min_ff, min_in;
   logic signed [SampleW-1:0] max_ff, max_in;

   logic signed [SampleW-1:0] offset_eff;
   logic signed [ProdW-1:0]   prod;
   logic signed [ProdW-1:0]   biased;
   logic signed [ProdW-1:0]   quot;
   logic signed [SampleW-1:0] scaled;
   logic signed [SampleW:0]   diff;
   logic signed [SampleW-1:0] diff_sat;
   logic signed [SampleW:0]   mid_sum;

   // begin clears the offset before this sample is corrected
   assign offset_eff = ctl.cal_begin ? '0 : offset_ff;

   always_comb begin
      prod   = ProdW'(raw_val) * ProdW'($signed({1'b0, gain}));
      // round toward zero: bias negative products before the shift
      biased = prod + (prod[ProdW-1] ? GainBias : '0);
      quot   = biased >>> GAIN_FRAC_BITS;
      if (quot > SatHi) begin
         scaled = 16'sh7fff;
      end else if (quot < SatLo) begin
         scaled = 16'sh8000;
      end else begin
         scaled = quot[SampleW-1:0];
      end
      diff = {scaled[SampleW-1], scaled} - {offset_eff[SampleW-1], offset_eff};
      if (diff[SampleW] != diff[SampleW-1]) begin
         diff_sat = diff[SampleW] ? 16'sh8000 : 16'sh7fff;
      end else begin
         diff_sat = diff[SampleW-1:0];
      end
      corr = ctl.pass_raw ? raw_val : diff_sat;
   end

   assign mid_sum = {min_ff[SampleW-1], min_ff} + {max_ff[SampleW-1], max_ff};

   always_comb begin
      offset_in = offset_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      if (ctl.load) begin
         if (ctl.cal_begin) begin
            offset_in = '0;
            min_in    = corr;
            max_in    = corr;
         end else if (ctl.cal_end) begin
            // floor of the midpoint
            offset_in = mid_sum[SampleW:1];
         end else if (ctl.tracking) begin
            if (corr < min_ff) begin
               min_in = corr;
            end
            if (corr > max_ff) begin
               max_in = corr;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         min_ff    <= '0;
         max_ff    <= '0;
      end else begin
         offset_ff <= offset_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
      end
   end

   `MHIC_ASSERT(a_min_le_max, clock, reset, min_ff <= max_ff, "axis minimum above maximum")
   `MHIC_ASSERT(a_begin_clears, clock, reset,
      ctl.load && ctl.cal_begin |=> offset_ff == '0 && min_ff == max_ff,
      "begin did not clear offset or seed min/max")
   `MHIC_ASSERT(a_idle_holds, clock, reset,
      !ctl.load |=> $stable(offset_ff) && $stable(min_ff) && $stable(max_ff),
      "calibration state changed without a transfer")

endmodule

/* rtl/core/magnetometer_hard_iron_correction.sv */
// Top level of the magnetometer hard-iron correction block.
//
// Input stream req_*: one transfer carries the three raw sensor words and an
// action code (plain sample, begin calibration, end calibration). Output
// stream rsp_*: one transfer per input with the three corrected axis values
// and the calibration tracking flag. csr_* writes the gain and raw-mode
// registers; write them only while no item is in flight.
//
// An item taken on req_* passes the input register, then the result register,
// before it shows on rsp_*. Throughput: one item per cycle while rsp_tready stays high;
// per-axis multiply, saturate, subtract and min/max compare sit between the
// two registers. Offsets and min/max update as an item enters the result
// register, so the following item sees them at once.
//
// Reset clears offsets, min/max, tracking and both valid flags, and loads
// unity gains with raw mode off. A waiting result holds while rsp_tready is low;
// the input register still takes one more item, then req_tready drops.
`include "magnetometer_hard_iron_correction_defines.svh"

module magnetometer_hard_iron_correction
   import mhic_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [47:0]         req_tdata,   // word_x, word_z_raw, word_y
   input  logic [1:0]          req_tuser,   // action

   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [47:0]         rsp_tdata,   // out_x, out_y, out_z
   output logic [0:0]          rsp_tuser,   // tracking

   input  logic                csr_we,
   input  logic [CsrAddrW-1:0] csr_addr,
   input  logic [GainW-1:0]    csr_wdata
);

   logic [GainW-1:0] gain_x_ff, gain_x_in;
   logic [GainW-1:0] gain_y_ff, gain_y_in;
   logic [GainW-1:0] gain_z_ff, gain_z_in;
   logic             pass_raw_ff, pass_raw_in;

   logic               s1_vld_ff, s1_vld_in;
   logic [SampleW-1:0] s1_word_x_ff, s1_word_x_in;
   logic [SampleW-1:0] s1_word_z_ff, s1_word_z_in;
   logic [SampleW-1:0] s1_word_y_ff, s1_word_y_in;
   logic [1:0]         s1_action_ff, s1_action_in;

   logic        rsp_vld_ff, rsp_vld_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic        rsp_trk_ff, rsp_trk_in;
   logic        cal_tracking_ff, cal_tracking_in;

   logic req_xfer, s2_load, s1_move;
   logic is_begin, is_end;
   axis_ctl_type ctl;
   logic signed [SampleW-1:0] raw_z;
   logic signed [SampleW-1:0] corr_x, corr_y, corr_z;

   // configuration registers
   always_comb begin
      gain_x_in   = gain_x_ff;
      gain_y_in   = gain_y_ff;
      gain_z_in   = gain_z_ff;
      pass_raw_in = pass_raw_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_GAIN_X:   gain_x_in   = csr_wdata;
            CSR_GAIN_Y:   gain_y_in   = csr_wdata;
            CSR_GAIN_Z:   gain_z_in   = csr_wdata;
            CSR_PASS_RAW: pass_raw_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // handshake
   assign s2_load    = !rsp_vld_ff || rsp_tready;
   assign s1_move    = s1_vld_ff && s2_load;
   assign req_tready = !s1_vld_ff || s2_load;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      s1_vld_in    = s1_vld_ff;
      s1_word_x_in = s1_word_x_ff;
      s1_word_z_in = s1_word_z_ff;
      s1_word_y_in = s1_word_y_ff;
      s1_action_in = s1_action_ff;
      if (req_xfer) begin
         s1_vld_in    = 1'b1;
         s1_word_x_in = req_tdata[15:0];
         s1_word_z_in = req_tdata[31:16];
         s1_word_y_in = req_tdata[47:32];
         s1_action_in = req_tuser;
      end else if (s1_move) begin
         s1_vld_in = 1'b0;
      end
   end

   // action code three falls through as a plain sample
   assign is_begin = s1_action_ff == ACT_CAL_BEGIN;
   assign is_end   = s1_action_ff == ACT_CAL_END;
   assign raw_z    = $signed(~s1_word_z_ff + 16'd1);

   always_comb begin
      ctl.load      = s1_move;
      ctl.cal_begin = is_begin;
      ctl.cal_end   = is_end;
      ctl.tracking  = cal_tracking_ff;
      ctl.pass_raw  = pass_raw_ff;
   end

   mhic_axis #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_axis_x (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .raw_val ($signed(s1_word_x_ff)),
      .gain    (gain_x_ff),
      .corr    (corr_x)
   );

   mhic_axis #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_axis_y (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .raw_val ($signed(s1_word_y_ff)),
      .gain    (gain_y_ff),
      .corr    (corr_y)
   );

   mhic_axis #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_axis_z (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .raw_val (raw_z),
      .gain    (gain_z_ff),
      .corr    (corr_z)
   );

   always_comb begin
      cal_tracking_in = cal_tracking_ff;
      if (s1_move) begin
         if (is_begin) begin
            cal_tracking_in = 1'b1;
         end else if (is_end) begin
            cal_tracking_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      rsp_trk_in  = rsp_trk_ff;
      if (s1_move) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = {corr_z, corr_y, corr_x};
         rsp_trk_in  = cal_tracking_in;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_x_ff       <= GainOne;
         gain_y_ff       <= GainOne;
         gain_z_ff       <= GainOne;
         pass_raw_ff     <= 1'b0;
         s1_vld_ff       <= 1'b0;
         rsp_vld_ff      <= 1'b0;
         cal_tracking_ff <= 1'b0;
      end else begin
         gain_x_ff       <= gain_x_in;
         gain_y_ff       <= gain_y_in;
         gain_z_ff       <= gain_z_in;
         pass_raw_ff     <= pass_raw_in;
         s1_vld_ff       <= s1_vld_in;
         rsp_vld_ff      <= rsp_vld_in;
         cal_tracking_ff <= cal_tracking_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_x_ff <= s1_word_x_in;
      s1_word_z_ff <= s1_word_z_in;
      s1_word_y_ff <= s1_word_y_in;
      s1_action_ff <= s1_action_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_trk_ff   <= rsp_trk_in;
   end

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_trk_ff;

   `MHIC_ASSERT_NEVER(a_no_overwrite, clock, reset, req_xfer && s1_vld_ff && !s2_load, "input register overwritten while full")
   `MHIC_ASSERT(a_trk_matches, clock, reset, rsp_vld_ff |-> rsp_trk_ff == cal_tracking_ff, "result tracking flag differs from state")
   `MHIC_ASSERT(a_begin_tracks, clock, reset, s1_move && is_begin |=> rsp_vld_ff && rsp_trk_ff, "begin did not start tracking")

endmodule

/* verif/tb.sv */
// Self-checking stream testbench for the magnetometer hard-iron correction block.
`timescale 1ns / 100ps

module tb;
   import mhic_pkg::*;

   localparam int GainFracBits = 12;
   localparam int CycleLimit = 200000;
   localparam int LongStall = 80;
   localparam logic [1:0] ActSpare = 2'd3;   // unused code, behaves as a plain sample

   typedef struct packed {
      logic [15:0] wx;
      logic [15:0] wz;
      logic [15:0] wy;
      logic [1:0]  act;
   } sample_item;

   typedef struct packed {
      logic [2:0][15:0] axis;
      logic             tracking;
   } axis_result;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [47:0]         req_tdata = '0;   // word_x, word_z_raw, word_y
   logic [1:0]          req_tuser = '0;   // action
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [47:0]         rsp_tdata;        // out_x, out_y, out_z
   logic [0:0]          rsp_tuser;        // tracking
   logic                csr_we = 1'b0;
   logic [CsrAddrW-1:0] csr_addr = '0;
   logic [GainW-1:0]    csr_wdata = '0;

   // predictor state and register copies
   logic [15:0]        cfg_gain [3] = '{GainOne, GainOne, GainOne};
   logic               cfg_raw = 1'b0;
   logic signed [15:0] cal_offset [3] = '{0, 0, 0};
   logic signed [15:0] cal_min [3] = '{0, 0, 0};
   logic signed [15:0] cal_max [3] = '{0, 0, 0};
   logic               cal_active = 1'b0;

   sample_item sample_queue[$];
   axis_result expected_axes[$];

   int  error_count = 0;
   int  cycle_count = 0;
   bit  idle_on = 1'b1;
   bit  req_taken = 1'b0;
   int  req_gap = 0;
   int  rsp_gap = 0;
   int  stall_left = 0;
   int  stalls_asked = 0;
   int  stalls_served = 0;

   magnetometer_hard_iron_correction #(
      .GAIN_FRAC_BITS(GainFracBits)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   // one correction step: updates offsets and min/max, returns the output fields
   function automatic axis_result correct_sample(input sample_item it);
      logic signed [15:0] ax [3];
      axis_result r;
      longint prod;
      int acc;
      ax[0] = it.wx;
      ax[1] = it.wy;
      ax[2] = 16'(~it.wz + 16'd1);
      if (it.act == ACT_CAL_BEGIN) begin
         for (int i = 0; i < 3; i++) cal_offset[i] = '0;
      end
      if (!cfg_raw) begin
         for (int i = 0; i < 3; i++) begin
            prod = longint'(ax[i]) * longint'(cfg_gain[i]);
            prod = prod / (longint'(1) << GainFracBits);   // truncates toward zero
            ax[i] = clamp16(longint'(clamp16(prod)) - longint'(cal_offset[i]));
         end
      end
      if (it.act == ACT_CAL_BEGIN) begin
         for (int i = 0; i < 3; i++) begin
            cal_min[i] = ax[i];
            cal_max[i] = ax[i];
         end
         cal_active = 1'b1;
      end else if (it.act == ACT_CAL_END) begin
         for (int i = 0; i < 3; i++) begin
            acc = int'(cal_min[i]) + int'(cal_max[i]);
            cal_offset[i] = 16'(acc >>> 1);   // floor of the midpoint
         end
         cal_active = 1'b0;
      end else if (cal_active) begin
         for (int i = 0; i < 3; i++) begin
            if (ax[i] < cal_min[i]) cal_min[i] = ax[i];
            if (ax[i] > cal_max[i]) cal_max[i] = ax[i];
         end
      end
      for (int i = 0; i < 3; i++) r.axis[i] = ax[i];
      r.tracking = cal_active;
      return r;
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0: return 16'h0000;
               1: return 16'h7FFF;
               2: return 16'h8000;
               3: return 16'hFFFF;
               default: return 16'h0001;
            endcase
         end
         1, 2, 3: return 16'($urandom_range(0, 4095) - 2048);
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return GainOne;
         3: return 16'($urandom());
         default: return 16'($urandom_range(2048, 8192));
      endcase
   endfunction

   task automatic add_sample(input logic [15:0] wx, input logic [15:0] wz,
                             input logic [15:0] wy, input logic [1:0] act);
      sample_item it;
      it.wx = wx;
      it.wz = wz;
      it.wy = wy;
      it.act = act;
      sample_queue.push_back(it);
   endtask

   task automatic add_random(input logic [1:0] act);
      add_sample(pick_word(), pick_word(), pick_word(), act);
   endtask

   task automatic write_csr(input logic [CsrAddrW-1:0] addr, input logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (addr)
         CSR_GAIN_X: cfg_gain[0] = value;
         CSR_GAIN_Y: cfg_gain[1] = value;
         CSR_GAIN_Z: cfg_gain[2] = value;
         CSR_PASS_RAW: cfg_raw = value[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [15:0] gx, input logic [15:0] gy,
                             input logic [15:0] gz, input logic raw);
      write_csr(CSR_GAIN_X, gx);
      write_csr(CSR_GAIN_Y, gy);
      write_csr(CSR_GAIN_Z, gz);
      write_csr(CSR_PASS_RAW, {15'd0, raw});
   endtask

   // sender holds until every result is back and the pipe has settled
   task automatic drain();
      while (sample_queue.size() != 0 || expected_axes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // mostly complete calibration runs with random content, some noise between
   task automatic queue_random_samples(input int count);
      int made;
      int run_len;
      int tail;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 9) < 7) begin
            add_random(ACT_CAL_BEGIN);
            run_len = $urandom_range(0, 12);
            for (int k = 0; k < run_len; k++) begin
               add_random(($urandom_range(0, 15) == 0) ? ACT_CAL_BEGIN : ACT_SAMPLE);
            end
            add_random(ACT_CAL_END);
            tail = $urandom_range(0, 3);
            for (int k = 0; k < tail; k++) add_random(ACT_SAMPLE);
            made += run_len + 2 + tail;
         end else begin
            tail = $urandom_range(1, 4);
            for (int k = 0; k < tail; k++) add_random(2'($urandom_range(0, 3)));
            made += tail;
         end
      end
   endtask

   // driver: acceptance at the rising edge, new values at the falling edge
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_axes.push_back(correct_sample(sample_queue.pop_front()));
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // offered item not taken yet: hold it
      end else if (req_gap > 0) begin
         req_gap--;
         req_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         req_gap = $urandom_range(0, 5);
         req_tvalid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
         req_tvalid <= 1'b1;
         req_tdata <= {sample_queue[0].wy, sample_queue[0].wz, sample_queue[0].wx};
         req_tuser <= sample_queue[0].act;
      end else begin
         req_tvalid <= 1'b0;
      end
      req_taken = 1'b0;
   end

   // monitor: ready pattern at the falling edge, checks at the rising edge
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (stalls_asked != stalls_served) begin
         stalls_served++;
         stall_left = LongStall - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
         rsp_gap = $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      axis_result want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_axes.size() == 0) begin
            error_count++;
            $display("%0t: result transfer with none expected, got %h / %b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = expected_axes.pop_front();
            for (int i = 0; i < 3; i++) begin
               if (rsp_tdata[16*i +: 16] !== want.axis[i]) begin
                  error_count++;
                  $display("%0t: axis %0d mismatch, expected %0d, got %0d", $time, i,
                           $signed(want.axis[i]), $signed(rsp_tdata[16*i +: 16]));
               end
            end
            if (rsp_tuser[0] !== want.tracking) begin
               error_count++;
               $display("%0t: tracking mismatch, expected %b, got %b",
                        $time, want.tracking, rsp_tuser[0]);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // unity gains after reset: end with nothing tracked, extremes, every action
      add_sample(16'h1234, 16'h0010, 16'hFFF0, ACT_CAL_END);
      add_sample(16'h0000, 16'h0000, 16'h0000, ACT_SAMPLE);
      add_sample(16'h7FFF, 16'h8000, 16'h8000, ACT_SAMPLE);
      add_sample(16'h8000, 16'hFFFF, 16'h7FFF, ACT_SAMPLE);
      add_sample(16'hFFFF, 16'h0001, 16'h0001, ActSpare);
      add_sample(16'h0064, 16'hFF38, 16'hFFCE, ACT_CAL_BEGIN);
      add_sample(16'h00C8, 16'h0000, 16'h0032, ACT_SAMPLE);
      add_sample(16'hFF9C, 16'h0190, 16'h0010, ActSpare);
      add_sample(16'h0010, 16'h0020, 16'h0030, ACT_CAL_BEGIN);
      add_sample(16'h0300, 16'hFD00, 16'hFF00, ACT_SAMPLE);
      add_sample(16'hFD00, 16'h0300, 16'h0100, ACT_SAMPLE);
      add_sample(16'h0000, 16'h0000, 16'h0000, ACT_CAL_END);
      add_sample(16'h7FFF, 16'h8000, 16'h8000, ACT_SAMPLE);
      add_sample(16'h8000, 16'h7FFF, 16'h7FFF, ACT_CAL_BEGIN);
      add_sample(16'h8000, 16'h7FFF, 16'h7FFF, ACT_CAL_END);
      add_sample(16'h0001, 16'hFFFF, 16'h0002, ACT_SAMPLE);
      drain();

      // largest gains: products saturate
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      add_sample(16'h7FFF, 16'h8000, 16'h8000, ACT_SAMPLE);
      add_sample(16'h0001, 16'h0001, 16'hFFFF, ACT_CAL_BEGIN);
      add_sample(16'h0010, 16'hFFF0, 16'h0800, ACT_SAMPLE);
      add_sample(16'h0000, 16'h0000, 16'h0000, ACT_CAL_END);
      add_sample(16'h4000, 16'hC000, 16'h2000, ACT_SAMPLE);
      drain();

      // zero and tiny gains: truncation toward zero
      set_config(16'h0000, 16'h0001, 16'h0FFF, 1'b0);
      add_sample(16'h7FFF, 16'h0FFF, 16'hFFFF, ACT_SAMPLE);
      add_sample(16'h8000, 16'h0001, 16'hF000, ACT_SAMPLE);
      drain();

      // raw mode calibrates on the assembled values
      set_config(16'h2000, 16'h0800, 16'h1800, 1'b1);
      add_sample(16'h0100, 16'h0200, 16'h0300, ACT_CAL_BEGIN);
      add_sample(16'hF000, 16'h1000, 16'h8000, ACT_SAMPLE);
      add_sample(16'h7FFF, 16'h8000, 16'h0000, ACT_CAL_END);
      add_sample(16'h1111, 16'h2222, 16'h3333, ACT_SAMPLE);
      drain();

      for (int p = 0; p < 5; p++) begin
         set_config(pick_gain(), pick_gain(), pick_gain(), $urandom_range(0, 3) == 0);
         if (p == 1) stalls_asked++;   // receiver holds off while items keep coming
         if (p == 4) idle_on = 1'b0;
         queue_random_samples(325);
         drain();
      end

      repeat (10) @(negedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
